FILE: rtl/core/sfla_pkg.sv
// ----------------------------------------------------------------------------
// sfla_pkg
// Shared types and constants of the slot free list allocator.
// ----------------------------------------------------------------------------
package sfla_pkg;

  // link memory geometry
  localparam int LINK_DEPTH = 1024;
  localparam int LINK_AW    = 10;
  localparam int IDX_W      = 11;

  // field widths
  localparam int ADDR_W  = 32;
  localparam int SW_W    = 11;
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 1;

  // command codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_WORDS   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 1'd1;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_SLOT = 2'd1,
    ST_OUTSIDE = 2'd2
  } status_t;

endpackage

FILE: rtl/core/sfla_if.sv
// ----------------------------------------------------------------------------
// sfla_if
// Request and response channels of the slot free list allocator.
// ----------------------------------------------------------------------------

// request channel: allocate or free
interface sfla_req_if import sfla_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              command;
  logic [ADDR_W-1:0] slot_address;

  modport source (output valid, output command, output slot_address, input ready);
  modport sink   (input valid, input command, input slot_address, output ready);
endinterface

// response channel: one result per request
interface sfla_rsp_if import sfla_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] granted_address;
  status_t           status;
  logic [IDX_W-1:0]  free_slots;
  logic              all_free;

  modport source (output valid, output granted_address, output status,
                  output free_slots, output all_free, input ready);
  modport sink   (input valid, input granted_address, input status,
                  input free_slots, input all_free, output ready);
endinterface

FILE: rtl/core/slot_free_list_allocator.sv
// ----------------------------------------------------------------------------
// slot_free_list_allocator
// Fixed-size slot allocator for one page, with an embedded free list.
// ----------------------------------------------------------------------------
// Hands out and takes back slots of slot_words words inside a page of
// PAGE_WORDS words starting at base_address. Free slots are chained in a
// 1024-entry link memory (registered read) with a head index and a free
// count. One request is worked on at a time. An allocate goes through
// accept, link memory read of the head entry, then the result register. A
// free divides the page offset by slot_words in a restoring divider that
// retires one quotient bit per cycle for PW = $clog2(PAGE_WORDS+1) bits (11
// for the default page), then pushes the slot with one link memory write
// if the quotient is below the slot count. An address outside the page is
// answered without the divide. The next request is taken while a result still
// waits on the response channel. After reset and after every configuration
// write the list is rebuilt by a pass over all 1024 link memory entries, one
// entry per cycle, during which no request is taken; the same divider computes
// the slot count PAGE_WORDS / slot_words (capped at 1024) in the background.
// ----------------------------------------------------------------------------
module slot_free_list_allocator import sfla_pkg::*; #(
  parameter int PAGE_WORDS = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  sfla_req_if.sink             in_req,
  sfla_rsp_if.source           out_rsp
);

  // dividend width, compare width and iteration counter width
  localparam int PW   = $clog2(PAGE_WORDS + 1);
  localparam int CMPW = (PW > IDX_W) ? PW : IDX_W;
  localparam int CNTW = $clog2(PW + 1);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_ALLOC = 5'b00100,
    S_DIV   = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  // control and configuration state
  state_t             state_r, state_nxt;
  logic [LINK_AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [SW_W-1:0]    sw_r, sw_nxt;
  logic [ADDR_W-1:0]  base_r, base_nxt;
  logic [IDX_W-1:0]   head_r, head_nxt;
  logic [IDX_W-1:0]   fc_r, fc_nxt;
  logic [IDX_W-1:0]   total_r, total_nxt;

  // divider
  logic               div_busy_r, div_busy_nxt;
  logic [CNTW-1:0]    div_cnt_r, div_cnt_nxt;
  logic [PW-1:0]      div_dvd_r, div_dvd_nxt;
  logic [PW-1:0]      div_q_r, div_q_nxt;
  logic [SW_W-1:0]    div_rem_r, div_rem_nxt;

  // result and output registers
  logic [ADDR_W-1:0]  res_addr_r, res_addr_nxt;
  status_t            res_status_r, res_status_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0]  out_addr_r, out_addr_nxt;
  status_t            out_status_r, out_status_nxt;
  logic [IDX_W-1:0]   out_free_r, out_free_nxt;
  logic               out_all_r, out_all_nxt;

  // link memory
  logic [IDX_W-1:0]   link_mem [LINK_DEPTH];
  logic               mem_we;
  logic [LINK_AW-1:0] mem_wa;
  logic [IDX_W-1:0]   mem_wd;
  logic [IDX_W-1:0]   mem_rd_r;

  // datapath helpers
  logic [SW_W:0]      rem_sh;
  logic               rem_ge;
  logic [ADDR_W-1:0]  offset;
  logic [CMPW-1:0]    q_ext;
  logic [CMPW-1:0]    total_ext;
  logic [2*IDX_W-1:0] grant_prod;
  logic               in_xfer;
  logic               out_free_slot;

  assign in_xfer       = in_req.valid && in_req.ready;
  assign out_free_slot = !out_valid_r || out_rsp.ready;

  // one restoring divide step
  assign rem_sh = {div_rem_r, div_dvd_r[PW-1]};
  assign rem_ge = rem_sh >= {1'b0, sw_r};

  assign offset     = in_req.slot_address - base_r;
  assign q_ext      = CMPW'(div_q_r);
  assign total_ext  = CMPW'(total_r);
  assign grant_prod = head_r * sw_r;

  // next state logic
  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    sw_nxt         = sw_r;
    base_nxt       = base_r;
    head_nxt       = head_r;
    fc_nxt         = fc_r;
    total_nxt      = total_r;
    div_busy_nxt   = div_busy_r;
    div_cnt_nxt    = div_cnt_r;
    div_dvd_nxt    = div_dvd_r;
    div_q_nxt      = div_q_r;
    div_rem_nxt    = div_rem_r;
    res_addr_nxt   = res_addr_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r;
    out_addr_nxt   = out_addr_r;
    out_status_nxt = out_status_r;
    out_free_nxt   = out_free_r;
    out_all_nxt    = out_all_r;
    mem_we         = 1'b0;
    mem_wa         = clr_cnt_r;
    mem_wd         = IDX_W'(clr_cnt_r) + 1'b1;

    // divider iteration
    if (div_busy_r) begin
      div_rem_nxt = rem_ge ? SW_W'(rem_sh - {1'b0, sw_r}) : rem_sh[SW_W-1:0];
      div_q_nxt   = {div_q_r[PW-2:0], rem_ge};
      div_dvd_nxt = {div_dvd_r[PW-2:0], 1'b0};
      div_cnt_nxt = div_cnt_r - 1'b1;
      if (div_cnt_r == CNTW'(1)) begin
        div_busy_nxt = 1'b0;
      end
    end

    // response channel drains
    if (out_valid_r && out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      // rebuild pass: entry i links to i + 1
      S_CLEAR: begin
        mem_we      = 1'b1;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == {LINK_AW{1'b1}}) begin
          total_nxt = (q_ext > CMPW'(LINK_DEPTH)) ? IDX_W'(LINK_DEPTH) : q_ext[IDX_W-1:0];
          fc_nxt    = total_nxt;
          head_nxt  = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          res_addr_nxt = '0;
          if (in_req.command == CMD_ALLOC) begin
            if (fc_r == '0) begin
              res_status_nxt = ST_NO_SLOT;
              state_nxt      = S_DONE;
            end else begin
              state_nxt = S_ALLOC;
            end
          end else if (offset >= ADDR_W'(PAGE_WORDS)) begin
            res_status_nxt = ST_OUTSIDE;
            state_nxt      = S_DONE;
          end else begin
            div_busy_nxt = 1'b1;
            div_cnt_nxt  = CNTW'(PW);
            div_dvd_nxt  = offset[PW-1:0];
            div_q_nxt    = '0;
            div_rem_nxt  = '0;
            state_nxt    = S_DIV;
          end
        end
      end
      // pop the head; link read data arrives this cycle
      S_ALLOC: begin
        res_addr_nxt   = base_r + ADDR_W'(grant_prod);
        res_status_nxt = ST_OK;
        head_nxt       = head_r[IDX_W-1] ? head_r : mem_rd_r;
        fc_nxt         = fc_r - 1'b1;
        state_nxt      = S_DONE;
      end
      // push the freed slot once the quotient is ready, if it is below the slot count
      S_DIV: begin
        if (!div_busy_r) begin
          if (q_ext >= total_ext) begin
            res_status_nxt = ST_OUTSIDE;
          end else begin
            res_status_nxt = ST_OK;
            mem_we         = 1'b1;
            mem_wa         = q_ext[LINK_AW-1:0];
            mem_wd         = head_r;
            head_nxt       = q_ext[IDX_W-1:0];
            if (fc_r < total_r) begin
              fc_nxt = fc_r + 1'b1;
            end
          end
          state_nxt = S_DONE;
        end
      end
      // hand the result to the output register
      S_DONE: begin
        if (out_free_slot) begin
          out_valid_nxt  = 1'b1;
          out_addr_nxt   = res_addr_r;
          out_status_nxt = res_status_r;
          out_free_nxt   = fc_r;
          out_all_nxt    = (fc_r == total_r);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase

    // configuration write restarts the rebuild
    if (cfg_we) begin
      if (cfg_index == CFG_SLOT_WORDS) begin
        sw_nxt = (cfg_wdata[SW_W-1:0] == '0) ? SW_W'(1) : cfg_wdata[SW_W-1:0];
      end else if (cfg_index == CFG_BASE_ADDRESS) begin
        base_nxt = cfg_wdata[ADDR_W-1:0];
      end
      state_nxt    = S_CLEAR;
      clr_cnt_nxt  = '0;
      div_busy_nxt = 1'b1;
      div_cnt_nxt  = CNTW'(PW);
      div_dvd_nxt  = PW'(PAGE_WORDS);
      div_q_nxt    = '0;
      div_rem_nxt  = '0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      sw_r        <= SW_W'(1);
      base_r      <= '0;
      head_r      <= '0;
      fc_r        <= '0;
      total_r     <= '0;
      div_busy_r  <= 1'b1;
      div_cnt_r   <= CNTW'(PW);
      div_dvd_r   <= PW'(PAGE_WORDS);
      div_q_r     <= '0;
      div_rem_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      sw_r        <= sw_nxt;
      base_r      <= base_nxt;
      head_r      <= head_nxt;
      fc_r        <= fc_nxt;
      total_r     <= total_nxt;
      div_busy_r  <= div_busy_nxt;
      div_cnt_r   <= div_cnt_nxt;
      div_dvd_r   <= div_dvd_nxt;
      div_q_r     <= div_q_nxt;
      div_rem_r   <= div_rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    res_addr_r   <= res_addr_nxt;
    res_status_r <= res_status_nxt;
    out_addr_r   <= out_addr_nxt;
    out_status_r <= out_status_nxt;
    out_free_r   <= out_free_nxt;
    out_all_r    <= out_all_nxt;
  end

  // link memory: one write port, one registered read at the head
  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_wa] <= mem_wd;
    end
    mem_rd_r <= link_mem[head_r[LINK_AW-1:0]];
  end

  // channel outputs
  assign in_req.ready            = (state_r == S_IDLE);
  assign out_rsp.valid           = out_valid_r;
  assign out_rsp.granted_address = out_addr_r;
  assign out_rsp.status          = out_status_r;
  assign out_rsp.free_slots      = out_free_r;
  assign out_rsp.all_free        = out_all_r;

endmodule
